// ----- hw/rtl/rrp_pkg.sv -----
// Shared constants and types for the round-robin pairing generator.
// No dependencies; every other file of the block but rrp_fifo refers to this package.
package rrp_pkg;

  localparam int MAX_TEAMS_DEF = 32;
  localparam int MAX_LEGS_DEF  = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int TC_W       = 6;
  localparam int LEGS_W     = 3;
  localparam int ROUND_W    = 7;
  localparam int SLOT_OUT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TEAM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEGS       = 2'd1;

  localparam logic [TC_W-1:0]   TEAM_COUNT_RESET = 6'd0;
  localparam logic [LEGS_W-1:0] LEGS_RESET       = 3'd2;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] home_slot;
    logic [SLOT_OUT_W-1:0] away_slot;
    logic                  out_of_range;
    logic                  last;
  } res_t;

endpackage

// ----- hw/rtl/rrp_fifo.sv -----
// Small first-in first-out queue used between the pairing stages and as the result queue.
// Depends on nothing; the depth must be a power of two of at least two.
module rrp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/rrp_front.sv -----
// Front stage: accepts a round request and classifies it by repeated subtraction.
// Produces the rotation, the swap flag and the out-of-range flag; uses rrp_pkg.
module rrp_front #(
  parameter int SlotW = 6,
  parameter int LgW   = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [rrp_pkg::ROUND_W-1:0] round_number_i,
  input  logic [SlotW-1:0]            m_i,
  input  logic [LgW-1:0]              lg_i,
  input  logic                        too_few_i,
  input  logic                        job_full_i,
  output logic                        job_push_o,
  output logic [SlotW-1:0]            job_r_o,
  output logic                        job_swap_o,
  output logic                        job_oor_o
);

  localparam int CmpW = (rrp_pkg::ROUND_W > SlotW) ? rrp_pkg::ROUND_W : SlotW;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_e;

  front_state_e   state_q;
  logic [CmpW-1:0] rem_q;
  logic [LgW-1:0]  k_q;
  logic            over, fin;

  assign over       = too_few_i || (k_q >= lg_i);
  assign fin        = over || (rem_q < CmpW'(m_i));
  assign full_o     = (state_q != F_IDLE);
  assign job_push_o = (state_q == F_DIV) && fin && !job_full_i;
  assign job_r_o    = over ? '0 : SlotW'(rem_q);
  assign job_swap_o = (k_q != '0);
  assign job_oor_o  = over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      rem_q   <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            rem_q   <= CmpW'(round_number_i);
            k_q     <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          if (fin) begin
            if (!job_full_i) begin
              state_q <= F_IDLE;
            end
          end else begin
            rem_q <= rem_q - CmpW'(m_i);
            k_q   <= k_q + LgW'(1);
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rrp_back.sv -----
// Back stage: walks the pairs of one classified round, one pair per cycle while the result
// queue has room. Skips the pair with the bye slot and marks the final beat; uses rrp_pkg.
module rrp_back #(
  parameter int SlotW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic [SlotW-1:0]  job_r_i,
  input  logic              job_swap_i,
  input  logic              job_oor_i,
  input  logic [SlotW-1:0]  n_i,
  input  logic [SlotW-1:0]  m_i,
  input  logic [SlotW-1:0]  npairs_i,
  input  logic              has_bye_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output rrp_pkg::res_t     res_o
);

  localparam int SumW = SlotW + 1;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

  back_state_e     state_q;
  logic [SlotW-1:0] r_q, i_q, cnt_q;
  logic             swap_q, oor_q;
  logic [SumW-1:0]  ta, tb, ta_mod, tb_mod;
  logic [SlotW-1:0] a, b;
  logic             bye, last;

  always_comb begin
    ta = SumW'(i_q) + SumW'(m_i) - SumW'(r_q) - SumW'(1);
    tb = SumW'(m_i) - SumW'(1) - SumW'(i_q) + SumW'(m_i) - SumW'(r_q);
    ta_mod = (ta >= SumW'(m_i)) ? ta - SumW'(m_i) : ta;
    tb_mod = (tb >= SumW'(m_i)) ? tb - SumW'(m_i) : tb;
    a = (i_q == '0) ? '0 : SlotW'(ta_mod) + SlotW'(1);
    b = SlotW'(tb_mod) + SlotW'(1);
    bye  = has_bye_i && ((a == n_i - SlotW'(1)) || (b == n_i - SlotW'(1)));
    last = (cnt_q + SlotW'(1) == npairs_i);
  end

  always_comb begin
    res_o = '0;
    if (oor_q) begin
      res_o.out_of_range = 1'b1;
      res_o.last         = 1'b1;
    end else begin
      res_o.home_slot = rrp_pkg::SLOT_OUT_W'(swap_q ? b : a);
      res_o.away_slot = rrp_pkg::SLOT_OUT_W'(swap_q ? a : b);
      res_o.last      = last;
    end
  end

  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == B_RUN) && !res_full_i && (oor_q || !bye);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      r_q     <= '0;
      swap_q  <= 1'b0;
      oor_q   <= 1'b0;
      i_q     <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            r_q     <= job_r_i;
            swap_q  <= job_swap_i;
            oor_q   <= job_oor_i;
            i_q     <= '0;
            cnt_q   <= '0;
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (oor_q) begin
            if (!res_full_i) begin
              state_q <= B_IDLE;
            end
          end else if (bye) begin
            i_q <= i_q + SlotW'(1);
          end else if (!res_full_i) begin
            i_q   <= i_q + SlotW'(1);
            cnt_q <= cnt_q + SlotW'(1);
            if (last) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/round_robin_pairing.sv -----
// Round-robin pairing generator by the circle method: top level and registers.
// Instantiates rrp_front, rrp_fifo and rrp_back; uses rrp_pkg.
// Flow: the front stage classifies a request by repeated subtraction of the slot count minus
// one, then the back stage emits one pairing a cycle while the result queue has room.
// A new request is taken only once the front stage has passed the last one to the job queue.
// Reset: team_count returns to 0, legs to 2, and both queues are emptied.
module round_robin_pairing #(
  parameter int MAX_TEAMS = rrp_pkg::MAX_TEAMS_DEF,
  parameter int MAX_LEGS  = rrp_pkg::MAX_LEGS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [rrp_pkg::ROUND_W-1:0]    round_number_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [rrp_pkg::SLOT_OUT_W-1:0] home_slot_o,
  output logic [rrp_pkg::SLOT_OUT_W-1:0] away_slot_o,
  output logic                           out_of_range_o,
  output logic                           last_o
);

  localparam int SlotW = $clog2(MAX_TEAMS + 2);
  localparam int LgW   = $clog2(MAX_LEGS + 1);
  localparam int JobW  = SlotW + 2;
  localparam int ResW  = $bits(rrp_pkg::res_t);

  logic [rrp_pkg::TC_W-1:0]   tc_q;
  logic [rrp_pkg::LEGS_W-1:0] legs_q;

  logic [rrp_pkg::TC_W-1:0] teams;
  logic                     too_few, has_bye;
  logic [SlotW-1:0]         n, m, npairs;
  logic [LgW-1:0]           lg;

  logic             job_push, job_full, job_pop, job_empty;
  logic [SlotW-1:0] f_r;
  logic             f_swap, f_oor;
  logic [JobW-1:0]  job_wdata, job_rdata;

  logic          res_push, res_full;
  rrp_pkg::res_t res_w, res_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= rrp_pkg::TEAM_COUNT_RESET;
      legs_q <= rrp_pkg::LEGS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrp_pkg::REG_TEAM_COUNT: tc_q   <= rrp_pkg::TC_W'(cfg_wdata_i);
        rrp_pkg::REG_LEGS:       legs_q <= rrp_pkg::LEGS_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    teams = ({1'b0, tc_q} > (rrp_pkg::TC_W + 1)'(MAX_TEAMS)) ?
            rrp_pkg::TC_W'(MAX_TEAMS) : tc_q;
    too_few = (teams < rrp_pkg::TC_W'(2));
    has_bye = teams[0];
    n       = SlotW'(teams) + SlotW'(has_bye);
    m       = n - SlotW'(1);
    npairs  = (n >> 1) - SlotW'(has_bye);
    lg      = ({1'b0, legs_q} > (rrp_pkg::LEGS_W + 1)'(MAX_LEGS)) ?
              LgW'(MAX_LEGS) : LgW'(legs_q);
  end

  rrp_front #(
    .SlotW(SlotW),
    .LgW  (LgW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .round_number_i(round_number_i),
    .m_i           (m),
    .lg_i          (lg),
    .too_few_i     (too_few),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_r_o       (f_r),
    .job_swap_o    (f_swap),
    .job_oor_o     (f_oor)
  );

  assign job_wdata = {f_oor, f_swap, f_r};

  rrp_fifo #(
    .W    (JobW),
    .DEPTH(rrp_pkg::QUEUE_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .full_o (job_full),
    .wdata_i(job_wdata),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .rdata_o(job_rdata)
  );

  rrp_back #(
    .SlotW(SlotW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .job_r_i    (job_rdata[SlotW-1:0]),
    .job_swap_i (job_rdata[SlotW]),
    .job_oor_i  (job_rdata[SlotW+1]),
    .n_i        (n),
    .m_i        (m),
    .npairs_i   (npairs),
    .has_bye_i  (has_bye),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_w)
  );

  rrp_fifo #(
    .W    (ResW),
    .DEPTH(rrp_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .wdata_i(res_w),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(res_r)
  );

  assign home_slot_o    = res_r.home_slot;
  assign away_slot_o    = res_r.away_slot;
  assign out_of_range_o = res_r.out_of_range;
  assign last_o         = res_r.last;

endmodule

// ----- hw/rtl/rrp_checker.sv -----
// Port-level checks for the round-robin pairing generator, bound to the top level.
// Depends on rrp_pkg and on the port list of round_robin_pairing.
module rrp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           empty,
  input logic                           pop,
  input logic [rrp_pkg::SLOT_OUT_W-1:0] home_slot_o,
  input logic [rrp_pkg::SLOT_OUT_W-1:0] away_slot_o,
  input logic                           out_of_range_o,
  input logic                           last_o
);

  // An out-of-range beat is always the only beat of its request.
  a_oor_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_of_range_o) |-> last_o)
    else $error("out-of-range beat without last");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_of_range_o) |-> (home_slot_o == '0 && away_slot_o == '0))
    else $error("out-of-range beat with non-zero slots");

  // A team never meets itself.
  a_distinct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_of_range_o) |-> (home_slot_o != away_slot_o))
    else $error("pairing sets a slot against itself");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(home_slot_o) && $stable(away_slot_o)
                          && $stable(out_of_range_o) && $stable(last_o)))
    else $error("waiting beat changed before it was taken");

endmodule

bind round_robin_pairing rrp_checker u_rrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .home_slot_o   (home_slot_o),
  .away_slot_o   (away_slot_o),
  .out_of_range_o(out_of_range_o),
  .last_o        (last_o)
);
